/* rtl/svm_kernel_evaluator_unit_macros.svh */
// assertion macros shared by the kernel evaluator modules
`ifndef SVM_KERNEL_EVALUATOR_UNIT_MACROS_SVH
`define SVM_KERNEL_EVALUATOR_UNIT_MACROS_SVH

// condition must never be seen at a clock edge outside reset
`define SVMK_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("svmk check failed");

// consequent must hold in the same cycle as the antecedent
`define SVMK_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svmk check failed");

// consequent must hold in the cycle after the antecedent
`define SVMK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svmk check failed");

`endif

/* rtl/svmk_pkg.sv */
// types and constants shared by the kernel evaluator modules
package svmk_pkg;

	localparam int ELEM_WIDTH = 16;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	typedef enum logic [1:0] {
		MODE_LINEAR,
		MODE_POLY,
		MODE_GAUSS,
		MODE_TANH
	} kmode_t;

	typedef enum logic [1:0] {
		REG_MODE,
		REG_DEGREE,
		REG_SCALE,
		REG_OFFSET
	} creg_t;

	typedef struct packed {
		kmode_t             mode;
		logic [2:0]         degree;
		logic [23:0]        scale;
		logic signed [31:0] offset;
	} cfg_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] elem_a;
		logic signed [ELEM_WIDTH-1:0] elem_b;
		logic                         last_elem;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] kernel_value;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               clip;
	} sat_t;

	function automatic sat_t sat32(logic signed [65:0] v);
		sat_t r;
		if (v > S32_MAX) begin
			r.val  = 32'sh7FFF_FFFF;
			r.clip = 1'b1;
		end else if (v < S32_MIN) begin
			r.val  = 32'sh8000_0000;
			r.clip = 1'b1;
		end else begin
			r.val  = v[31:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/svmk_queue.sv */
// two-entry queue of finished sums between the accumulate and function parts
`include "svm_kernel_evaluator_unit_macros.svh"
module svmk_queue #(
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] rdata
);
	import svmk_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [PW:0]       count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SVMK_ASSERT_NEVER(a_no_overflow, push && full)
	`SVMK_ASSERT_NEVER(a_no_underflow, pop && !valid)
endmodule

/* rtl/svmk_front.sv */
// accumulate stage: one element pair per cycle while the sum queue has room, saturating sum of products or squares
`include "svm_kernel_evaluator_unit_macros.svh"
module svmk_front #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  svmk_pkg::kmode_t            mode,
	input  svmk_pkg::sample_t           sample,
	input  logic                        push,
	output logic                        full,
	output logic                        q_push,
	output logic signed [ACC_WIDTH-1:0] q_data,
	input  logic                        q_full
);
	import svmk_pkg::*;

	localparam int TW = 2*ELEM_WIDTH + 2;
	localparam int SW = ((ACC_WIDTH > TW) ? ACC_WIDTH : TW) + 1;
	localparam logic signed [SW-1:0] AMAX =
		$signed({{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] AMIN = -AMAX - 1;

	logic signed [ACC_WIDTH-1:0]    acc_q;
	logic signed [2*ELEM_WIDTH-1:0] prod_ab;
	logic signed [ELEM_WIDTH:0]     diff;
	logic [ELEM_WIDTH:0]            udiff;
	logic [TW-1:0]                  sq;
	logic signed [SW-1:0]           sq_ext, term, sum;
	logic signed [ACC_WIDTH-1:0]    s_next;
	logic                           accept;

	always_comb begin
		prod_ab = sample.elem_a * sample.elem_b;
		diff    = (ELEM_WIDTH+1)'(sample.elem_a) - (ELEM_WIDTH+1)'(sample.elem_b);
		udiff   = diff[ELEM_WIDTH] ? (ELEM_WIDTH+1)'(-diff) : (ELEM_WIDTH+1)'(diff);
		sq      = TW'(udiff) * TW'(udiff);
		sq_ext  = $signed({{(SW-TW){1'b0}}, sq});
		if (mode == MODE_GAUSS) begin
			term = (sq_ext > AMAX) ? AMAX : sq_ext;
		end else begin
			term = SW'(prod_ab);
		end
		sum = SW'(acc_q) + term;
		if (sum > AMAX) begin
			s_next = AMAX[ACC_WIDTH-1:0];
		end else if (sum < AMIN) begin
			s_next = AMIN[ACC_WIDTH-1:0];
		end else begin
			s_next = sum[ACC_WIDTH-1:0];
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept && sample.last_elem;
	assign q_data = s_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= sample.last_elem ? '0 : s_next;
		end
	end

	`SVMK_ASSERT_NEXT(a_acc_cleared, accept && sample.last_elem, acc_q == '0)
endmodule

/* rtl/svmk_div.sv */
// restoring divider, one quotient bit per cycle
`include "svm_kernel_evaluator_unit_macros.svh"
module svmk_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [47:0] quot
);
	import svmk_pkg::*;

	logic [47:0] dvd_q;
	logic [31:0] rem_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;
	logic        qbit;

	always_comb begin
		trial = {rem_q, dvd_q[47]};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			dvd_q <= {dvd_q[46:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dvd_q;

	`SVMK_ASSERT_NEVER(a_done_not_busy, done_q && busy_q)
endmodule

/* rtl/svmk_back.sv */
// function sequencer: applies the kernel function to one finished sum at a time
`include "svm_kernel_evaluator_unit_macros.svh"
module svmk_back #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  svmk_pkg::cfg_t              cfg,
	input  logic                        q_valid,
	input  logic signed [ACC_WIDTH-1:0] q_data,
	output logic                        q_pop,
	output logic                        res_valid,
	output svmk_pkg::result_t           res,
	input  logic                        res_pop
);
	import svmk_pkg::*;

	// ceil(2^32/6) and ceil(2^32/24): exact floor division for series terms below 2^29
	localparam logic signed [32:0] RECIP6  = 33'sd715827883;
	localparam logic signed [32:0] RECIP24 = 33'sd178956971;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_PMUL, S_PACC, S_GHI, S_GLO, S_GSUM,
		S_EZ2, S_EZ3, S_EZ4, S_EZ5, S_ED3, S_ED4, S_ESQ, S_ESQA,
		S_EFIN, S_TDIV, S_OUT
	} state_t;

	state_t                      state_q;
	logic signed [ACC_WIDTH-1:0] s_q;
	logic signed [31:0]          p_q, u_q;
	logic                        flag_q, neg_q;
	logic [3:0]                  cnt_q;
	logic [41:0]                 hi_q;
	logic [31:0]                 z_q, z2_q, z3_q, z4_q, d3_q, e_q;
	logic signed [65:0]          prod_q;
	result_t                     pend_q, out_q;
	logic                        out_valid_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] sum_w, u_w, v_w, mag_w;
	logic [2:0]         deg_eff;
	sat_t               u_sat, p_sat, lin_sat;
	logic [60:0]        gsum;
	logic signed [33:0] e_new;
	logic [32:0]        e_round;
	logic [31:0]        den, num;
	logic [16:0]        t_mag;
	logic               div_start, div_busy, div_done;
	logic [47:0]        div_dividend, div_quot;
	logic [31:0]        div_divisor;
	logic               take_out;

	// per-sum helper values
	always_comb begin
		sum_w   = 66'(s_q) >>> 8;
		u_w     = sum_w + 66'sd65536;
		u_sat   = sat32(u_w);
		lin_sat = sat32(sum_w);
		p_sat   = sat32(prod_q >>> 16);
		v_w     = sum_w - 66'(cfg.offset);
		mag_w   = v_w[65] ? -v_w : v_w;
		if (cfg.degree == 3'd0) begin
			deg_eff = 3'd1;
		end else if (cfg.degree > 3'd4) begin
			deg_eff = 3'd4;
		end else begin
			deg_eff = cfg.degree;
		end
		gsum    = {1'b0, hi_q, 18'b0} + 61'(prod_q[41:0]);
		e_new   = 34'(Q30_ONE) - 34'(z_q) + 34'(z2_q >> 1) - 34'(d3_q)
			+ 34'(prod_q[63:32]);
		e_round = (33'(e_q) + 33'd8192) >> 14;
		den     = Q30_ONE + e_q;
		num     = Q30_ONE - e_q;
		t_mag   = div_quot[16:0];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PMUL: begin
				mul_a = 33'(p_q);
				mul_b = 33'(u_q);
			end
			S_GHI: begin
				mul_a = {15'b0, sum_w[35:18]};
				mul_b = {9'b0, cfg.scale};
			end
			S_GLO: begin
				mul_a = {15'b0, sum_w[17:0]};
				mul_b = {9'b0, cfg.scale};
			end
			S_EZ2: begin
				mul_a = {1'b0, z_q};
				mul_b = {1'b0, z_q};
			end
			S_EZ3, S_EZ4: begin
				mul_a = {1'b0, prod_q[61:30]};
				mul_b = {1'b0, z_q};
			end
			// z^3/6 and z^4/24 by reciprocal multiplication
			S_EZ5: begin
				mul_a = {1'b0, z3_q};
				mul_b = RECIP6;
			end
			S_ED3: begin
				mul_a = {1'b0, z4_q};
				mul_b = RECIP24;
			end
			S_ESQ: begin
				mul_a = {1'b0, e_q};
				mul_b = {1'b0, e_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider launch for the tanh quotient
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			S_EFIN: begin
				div_start    = (cfg.mode == MODE_TANH);
				div_dividend = {num, 16'b0} + 48'(den >> 1);
				div_divisor  = den;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	svmk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign take_out = (state_q == S_OUT) && (!out_valid_q || res_pop);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (take_out) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						s_q     <= q_data;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					unique case (cfg.mode)
						MODE_LINEAR: begin
							pend_q  <= {lin_sat.val, lin_sat.clip};
							state_q <= S_OUT;
						end
						MODE_POLY: begin
							p_q    <= u_sat.val;
							u_q    <= u_sat.val;
							flag_q <= u_sat.clip;
							cnt_q  <= 4'(deg_eff - 3'd1);
							if (deg_eff == 3'd1) begin
								pend_q  <= {u_sat.val, u_sat.clip};
								state_q <= S_OUT;
							end else begin
								state_q <= S_PMUL;
							end
						end
						MODE_GAUSS: begin
							if (s_q < 0 || cfg.scale == '0) begin
								z_q     <= '0;
								state_q <= S_EZ2;
							end else if (sum_w[65:36] != '0) begin
								pend_q  <= '0;
								state_q <= S_OUT;
							end else begin
								state_q <= S_GHI;
							end
						end
						MODE_TANH: begin
							neg_q <= v_w[65];
							if (mag_w[65:19] != '0) begin
								e_q     <= '0;
								state_q <= S_EFIN;
							end else begin
								z_q     <= {6'b0, mag_w[18:0], 7'b0};
								state_q <= S_EZ2;
							end
						end
					endcase
				end
				S_PMUL: begin
					state_q <= S_PACC;
				end
				S_PACC: begin
					p_q    <= p_sat.val;
					flag_q <= flag_q | p_sat.clip;
					if (cnt_q == 4'd1) begin
						pend_q  <= {p_sat.val, flag_q | p_sat.clip};
						state_q <= S_OUT;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_PMUL;
					end
				end
				S_GHI: begin
					state_q <= S_GLO;
				end
				S_GLO: begin
					hi_q    <= prod_q[41:0];
					state_q <= S_GSUM;
				end
				S_GSUM: begin
					if (gsum[60:36] != '0) begin
						pend_q  <= '0;
						state_q <= S_OUT;
					end else begin
						z_q     <= {6'b0, gsum[35:16], 6'b0};
						state_q <= S_EZ2;
					end
				end
				S_EZ2: begin
					state_q <= S_EZ3;
				end
				S_EZ3: begin
					z2_q    <= prod_q[61:30];
					state_q <= S_EZ4;
				end
				S_EZ4: begin
					z3_q    <= prod_q[61:30];
					state_q <= S_EZ5;
				end
				S_EZ5: begin
					z4_q    <= prod_q[61:30];
					state_q <= S_ED3;
				end
				S_ED3: begin
					d3_q    <= prod_q[63:32];
					state_q <= S_ED4;
				end
				S_ED4: begin
					e_q     <= e_new[31:0];
					cnt_q   <= 4'd8;
					state_q <= S_ESQ;
				end
				S_ESQ: begin
					state_q <= S_ESQA;
				end
				S_ESQA: begin
					e_q <= prod_q[61:30];
					if (cnt_q == 4'd1) begin
						state_q <= S_EFIN;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_ESQ;
					end
				end
				S_EFIN: begin
					if (cfg.mode == MODE_TANH) begin
						state_q <= S_TDIV;
					end else begin
						pend_q  <= {e_round[31:0], 1'b0};
						state_q <= S_OUT;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						pend_q  <= {(neg_q ? -32'(t_mag) : 32'(t_mag)), 1'b0};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (take_out) begin
						out_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`SVMK_ASSERT_IMPLIES(a_div_start_idle, div_start, !div_busy)
endmodule

/* rtl/svm_kernel_evaluator_unit.sv */
// top level of the streaming svm kernel evaluator
// Streaming SVM kernel evaluator in fixed point. Element pairs (Q4.12) are
// pushed one per cycle and summed by a saturating multiply-accumulate: the
// product a*b in linear, polynomial and tanh modes, the squared difference
// (a-b)^2 in gaussian mode. The pair marked last_elem closes a vector; its
// sum goes into a two-entry queue and the accumulator restarts at zero, so
// the next vector can stream in at once. A sequencer behind the queue applies
// the kernel function and places one Q16.16 result, with a saturation flag,
// in the output register. Input rate is one pair per cycle; full rises only
// while two finished sums wait for the sequencer. The gaussian and tanh
// functions are built on an exp series (one shared 33x33 multiplier, four
// terms with the divisions by 6 and 24 done as reciprocal multiplications,
// then eight squarings); tanh then forms its final quotient in the restoring
// divider. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write takes effect on the next cycle.
module svm_kernel_evaluator_unit #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	// input queue side
	input  logic                push,
	output logic                full,
	input  svmk_pkg::sample_t   sample,
	// result queue side
	output logic                empty,
	input  logic                pop,
	output svmk_pkg::result_t   result,
	// configuration write port
	input  logic                cfg_we,
	input  svmk_pkg::creg_t     cfg_index,
	input  logic [31:0]         cfg_data
);
	import svmk_pkg::*;

	cfg_t                        cfg_q;
	logic                        q_push, q_full, q_valid, q_pop;
	logic signed [ACC_WIDTH-1:0] q_wdata;
	logic [ACC_WIDTH-1:0]        q_rdata;
	logic                        res_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_LINEAR;
			cfg_q.degree <= 3'd1;
			cfg_q.scale  <= 24'd65536;
			cfg_q.offset <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   cfg_q.mode   <= kmode_t'(cfg_data[1:0]);
				REG_DEGREE: cfg_q.degree <= cfg_data[2:0];
				REG_SCALE:  cfg_q.scale  <= cfg_data[23:0];
				REG_OFFSET: cfg_q.offset <= cfg_data;
			endcase
		end
	end

	// accumulate part: one transaction per cycle while the sum queue has room
	svmk_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (cfg_q.mode),
		.sample (sample),
		.push   (push),
		.full   (full),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	// finished sums waiting for the function sequencer
	svmk_queue #(.DATA_W(ACC_WIDTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// kernel function sequencer with output register
	svmk_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    ($signed(q_rdata)),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (result),
		.res_pop   (pop)
	);

	assign empty = !res_valid;
endmodule
